### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication, always checked
`define ASSERT_NEXT_ALL(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/mire_pkg.sv
// ----------------------------------------------------------------------------
// mire_pkg
// Types and constants of the mouse input report engine.
// ----------------------------------------------------------------------------
package mire_pkg;

   localparam int NUM_BUTTONS = 6;
   localparam int LEVEL_W     = 6;
   localparam int EDGE_W      = 4;
   localparam int EXT_W       = (NUM_BUTTONS > LEVEL_W) ? NUM_BUTTONS : LEVEL_W;
   localparam int REPORT_W    = 5;
   localparam int CNT_W       = 8;
   localparam int MOTION_W    = 16;
   localparam int WHEEL_W     = 8;
   localparam int REQ_W       = 48;
   localparam int RSP_W       = 56;

   localparam logic [7:0] EDGE_IGNORE_MASK = 8'b0011_0000;
   localparam logic [7:0] REPORT_MASK      = 8'b0001_1111;
   localparam logic [7:0] BUTTON_MASK      = 8'b0011_1111;
   localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd32;

   // one classified tick, passed from front to back
   typedef struct packed {
      logic [LEVEL_W-1:0]        dbncd;
      logic                      changed;
      logic                      busy;
      logic signed [1:0]         scroll;
      logic signed [MOTION_W-1:0] dx;
      logic signed [MOTION_W-1:0] dy;
   } cls_type;

endpackage

### rtl/mire_front.sv
// ----------------------------------------------------------------------------
// mire_front
// Accepts ticks, decodes the wheel and debounces button releases.
// ----------------------------------------------------------------------------
module mire_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mire_pkg::REQ_W-1:0]    req_tdata,
   input  logic                          csr_we,
   input  logic [mire_pkg::CNT_W-1:0]    csr_wdata,
   input  logic                          q_full,
   output logic                          push,
   output mire_pkg::cls_type             cls
);

   logic [mire_pkg::CNT_W-1:0]   dbt_ff;
   logic [mire_pkg::LEVEL_W-1:0] prev_ff, prev_in;
   logic [mire_pkg::CNT_W-1:0]   cnt_ff [mire_pkg::NUM_BUTTONS];
   logic [mire_pkg::CNT_W-1:0]   cnt_in [mire_pkg::NUM_BUTTONS];
   logic                         wsame_ff, wsame_in;
   logic                         wdiff_ff, wdiff_in;

   logic [mire_pkg::LEVEL_W-1:0] levels;
   logic [mire_pkg::EDGE_W-1:0]  edges;
   logic                         wa, wb;
   logic [mire_pkg::EXT_W-1:0]   lev_ext, edge_ext, prev_ext, unpressed, dbn;
   logic signed [1:0]            scroll;

   assign req_tready = !q_full;
   assign push       = req_tvalid && req_tready;

   assign levels = req_tdata[5:0];
   assign edges  = req_tdata[9:6];
   assign wa     = req_tdata[10];
   assign wb     = req_tdata[11];

   always_comb begin
      wsame_in = wsame_ff;
      wdiff_in = wdiff_ff;
      scroll   = 2'sd0;
      if (wa != wb) begin
         wdiff_in = wa;
      end else if (wa != wsame_ff) begin
         scroll   = (wa ^ wdiff_ff) ? 2'sd1 : -2'sd1;
         wsame_in = wa;
      end

      lev_ext   = mire_pkg::EXT_W'(levels);
      edge_ext  = mire_pkg::EXT_W'(edges);
      prev_ext  = mire_pkg::EXT_W'(prev_ff);
      unpressed = lev_ext & (~edge_ext | mire_pkg::EXT_W'(mire_pkg::EDGE_IGNORE_MASK));
      dbn       = '0;
      for (int i = 0; i < mire_pkg::NUM_BUTTONS; i++) begin
         if (prev_ext[i] && unpressed[i]) begin
            cnt_in[i] = cnt_ff[i] + 1'b1;
            dbn[i]    = (cnt_in[i] < dbt_ff);
         end else begin
            cnt_in[i] = '0;
            dbn[i]    = !unpressed[i];
         end
      end
      prev_in = dbn[mire_pkg::LEVEL_W-1:0] & mire_pkg::BUTTON_MASK[mire_pkg::LEVEL_W-1:0];

      cls.dbncd   = prev_in;
      cls.busy    = req_tdata[44];
      cls.scroll  = scroll;
      cls.dx      = req_tdata[27:12];
      cls.dy      = req_tdata[43:28];
      cls.changed = ((prev_in & mire_pkg::REPORT_MASK[mire_pkg::LEVEL_W-1:0]) !=
                     (prev_ff & mire_pkg::REPORT_MASK[mire_pkg::LEVEL_W-1:0]))
                    || (cls.dx != '0) || (cls.dy != '0) || (scroll != 2'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dbt_ff   <= mire_pkg::DEBOUNCE_RESET;
         prev_ff  <= '0;
         wsame_ff <= 1'b0;
         wdiff_ff <= 1'b0;
         for (int i = 0; i < mire_pkg::NUM_BUTTONS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            dbt_ff <= csr_wdata;
         end
         if (push) begin
            prev_ff  <= prev_in;
            wsame_ff <= wsame_in;
            wdiff_ff <= wdiff_in;
            for (int i = 0; i < mire_pkg::NUM_BUTTONS; i++) begin
               cnt_ff[i] <= cnt_in[i];
            end
         end
      end
   end

endmodule

### rtl/mire_queue.sv
// ----------------------------------------------------------------------------
// mire_queue
// Two-entry queue of classified ticks between front and back.
// ----------------------------------------------------------------------------
module mire_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mire_pkg::cls_type wr_data,
   output logic              full,
   input  logic              pop,
   output logic              rd_valid,
   output mire_pkg::cls_type rd_data
);

   mire_pkg::cls_type slot_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;

   assign full     = (count_ff == 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

### rtl/mire_back.sv
// ----------------------------------------------------------------------------
// mire_back
// Accumulates buttons, motion and scroll into the report; drives results.
// ----------------------------------------------------------------------------
module mire_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  mire_pkg::cls_type          q_data,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [mire_pkg::RSP_W-1:0] rsp_tdata
);

   logic [mire_pkg::REPORT_W-1:0]   pend_ff, pend_in, sent_ff, sent_in, dmask;
   logic [mire_pkg::MOTION_W-1:0]   sx_ff, sx_in, sy_ff, sy_in;
   logic [mire_pkg::WHEEL_W-1:0]    sw_ff, sw_in;
   logic                            kill, load, commit;
   logic                            valid_ff;
   logic [mire_pkg::RSP_W-1:0]      data_ff, data_in;

   assign pop        = q_valid && (!valid_ff || rsp_tready);
   assign commit     = pop && q_data.changed;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign dmask      = q_data.dbncd[mire_pkg::REPORT_W-1:0] &
                       mire_pkg::REPORT_MASK[mire_pkg::REPORT_W-1:0];

   always_comb begin
      sent_in = sent_ff;
      kill    = 1'b0;
      if (q_data.busy) begin
         kill    = q_data.changed;
         pend_in = pend_ff;
         sx_in   = sx_ff;
         sy_in   = sy_ff;
         sw_in   = sw_ff;
      end else begin
         sent_in = pend_ff;
         pend_in = '0;
         sx_in   = '0;
         sy_in   = '0;
         sw_in   = '0;
      end
      pend_in = pend_in | dmask;
      sx_in   = sx_in + q_data.dx;
      sy_in   = sy_in + q_data.dy;
      sw_in   = sw_in + mire_pkg::WHEEL_W'(q_data.scroll);
      load    = q_data.changed && ((pend_in != sent_in) || (sx_in != '0) ||
                                   (sy_in != '0) || (sw_in != '0));
      data_in = '0;
      data_in[5:0] = q_data.dbncd;
      data_in[6]   = kill;
      data_in[7]   = load;
      if (load) begin
         data_in[12:8]  = pend_in;
         data_in[28:13] = sx_in;
         data_in[44:29] = sy_in;
         data_in[52:45] = sw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= '0;
         sent_ff  <= '0;
         sx_ff    <= '0;
         sy_ff    <= '0;
         sw_ff    <= '0;
      end else begin
         if (pop) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
         if (commit) begin
            pend_ff <= pend_in;
            sent_ff <= sent_in;
            sx_ff   <= sx_in;
            sy_ff   <= sy_in;
            sw_ff   <= sw_in;
         end
      end
   end

endmodule

### rtl/mouse_input_report_engine_top.sv
// ----------------------------------------------------------------------------
// mouse_input_report_engine_top
// Mouse tick processor: release debounce, wheel decode, report accumulation.
// ----------------------------------------------------------------------------
// Each request beat is one sensor tick and yields exactly one response beat.
// A tick goes from request to response through the queue slot, written by the
// front stage, which debounces the buttons and decodes the wheel, and then the
// response register, loaded by the back stage, which merges into the report.
// A new tick is taken every cycle unless the queue is full; the two-entry queue
// between the stages and the response register let either side stall on its own.
module mouse_input_report_engine_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // button_levels[5:0], button_edges[9:6], wheel_a[10], wheel_b[11],
   // motion_x[27:12], motion_y[43:28], bank_busy[44], zero[47:45]
   input  logic [mire_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // debounced_buttons[5:0], kill_bank[6], report_load[7],
   // report_buttons[12:8], report_x[28:13], report_y[44:29],
   // report_wheel[52:45], zero[55:53]
   output logic [mire_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                       csr_we,
   input  logic [mire_pkg::CNT_W-1:0] csr_wdata
);

   mire_pkg::cls_type f_cls, q_cls;
   logic              f_push, q_full, q_valid, b_pop;

   mire_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .push       (f_push),
      .cls        (f_cls)
   );

   mire_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_push),
      .wr_data  (f_cls),
      .full     (q_full),
      .pop      (b_pop),
      .rd_valid (q_valid),
      .rd_data  (q_cls)
   );

   mire_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_cls),
      .pop        (b_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/mire_checker.sv
// ----------------------------------------------------------------------------
// mire_checker
// Port-level checks of the mouse input report engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mire_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [mire_pkg::RSP_W-1:0] rsp_tdata
);

   `ASSERT_NEXT_ALL(a_reset_idle, clock, reset, !rsp_tvalid)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_IMPL(a_empty_zero, clock, reset, rsp_tvalid && !rsp_tdata[7],
                rsp_tdata[52:8] == '0)
   `ASSERT_IMPL(a_btn_in_rpt, clock, reset, rsp_tvalid && rsp_tdata[7],
                (rsp_tdata[12:8] & rsp_tdata[4:0]) == rsp_tdata[4:0])

endmodule

bind mouse_input_report_engine_top mire_checker u_mire_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
